>>> hdl/fmib_pkg.sv
// ----------------------------------------------------------------------------
// fmib_pkg
// Shared types and constants of the FM-index layout builder.
// ----------------------------------------------------------------------------
package fmib_pkg;

	localparam int unsigned OCC_INTERVAL_DEF          = 256;
	localparam int unsigned CHECKPOINT_INTERVAL_DEF   = 65536;
	localparam int unsigned FLAG_COUNTER_INTERVAL_DEF = 224;
	localparam int unsigned RATE_W                    = 11;
	localparam int unsigned POS_W                     = 32;
	localparam int unsigned Q_DEPTH                   = 2;
	localparam logic [RATE_W-1:0] RATE_RESET          = 11'd8;

	typedef enum logic [2:0] {
		KIND_BWT  = 3'd0,
		KIND_OCC  = 3'd1,
		KIND_CKPT = 3'd2,
		KIND_FLAG = 3'd3,
		KIND_SAMP = 3'd4,
		KIND_SENT = 3'd5,
		KIND_CUM  = 3'd6
	} kind_t;

	// classified row handed from the front to the back
	typedef struct packed {
		logic [1:0]       code;  // two-bit packing code
		logic             sent;  // sentinel row
		logic [2:0]       cidx;  // symbol count slot
		logic [POS_W-1:0] pos;
		logic             last;
	} fmib_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_UPD,
		ST_SLOT,
		ST_FIN
	} state_t;

	typedef enum logic [4:0] {
		SL_BWT,
		SL_CK0,
		SL_CK1,
		SL_CK2,
		SL_CK3,
		SL_OCC,
		SL_FL1,
		SL_FL2,
		SL_SMP,
		SL_LBWT,
		SL_LFL,
		SL_SENT,
		SL_CUM0,
		SL_CUM1,
		SL_CUM2,
		SL_CUM3,
		SL_CUM4
	} slot_t;

endpackage

>>> hdl/fmib_front.sv
// ----------------------------------------------------------------------------
// fmib_front
// Accepts rows and classifies the symbol for the back end.
// ----------------------------------------------------------------------------
module fmib_front import fmib_pkg::*; (
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       prev_symbol,
	input  logic [POS_W-1:0] suffix_pos,
	input  logic             is_last,
	input  logic             q_full,
	output logic             q_push,
	output fmib_item_t       q_item
);

	logic sent;

	// codes 4..7 all count as the sentinel
	assign sent = prev_symbol[2];

	always_comb begin
		q_item.sent = sent;
		q_item.code = sent ? 2'd1 : prev_symbol[1:0];
		q_item.cidx = sent ? 3'd0 : ({1'b0, prev_symbol[1:0]} + 3'd1);
		q_item.pos  = suffix_pos;
		q_item.last = is_last;
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

endmodule

>>> hdl/fmib_queue.sv
// ----------------------------------------------------------------------------
// fmib_queue
// Small flop FIFO between front and back.
// ----------------------------------------------------------------------------
module fmib_queue import fmib_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  fmib_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       pop_valid,
	output fmib_item_t pop_item
);

	localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned CW = $clog2(Q_DEPTH + 1);

	fmib_item_t    mem_q [Q_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign full      = (cnt_q == CW'(Q_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_item  = mem_q[rptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(Q_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(Q_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(do_pop);
		end
	end

endmodule

>>> hdl/fmib_back.sv
// ----------------------------------------------------------------------------
// fmib_back
// Divides by the sample rate, updates the layout state and emits results.
// ----------------------------------------------------------------------------
module fmib_back import fmib_pkg::*; #(
	parameter int unsigned OCC_INTERVAL          = OCC_INTERVAL_DEF,
	parameter int unsigned CHECKPOINT_INTERVAL   = CHECKPOINT_INTERVAL_DEF,
	parameter int unsigned FLAG_COUNTER_INTERVAL = FLAG_COUNTER_INTERVAL_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RATE_W-1:0] sample_rate,
	input  logic              q_valid,
	input  fmib_item_t        q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        stream_kind,
	output logic [63:0]       word,
	output logic              last_of_run
);

	localparam int unsigned OW = $clog2(OCC_INTERVAL);
	localparam int unsigned KW = $clog2(CHECKPOINT_INTERVAL);
	localparam int unsigned FW = $clog2(FLAG_COUNTER_INTERVAL);

	state_t      st_q, st_d;
	slot_t       slot_q, slot_d;
	fmib_item_t  item_q;

	logic [4:0]        div_cnt_q;
	logic [RATE_W-1:0] rem_q;
	logic [31:0]       quo_q;
	logic [RATE_W-1:0] dvs;
	logic [RATE_W:0]   trial;
	logic              ge;

	logic [31:0] rc_q, rc_n;
	logic [63:0] bwt_q;
	logic [31:0] sc_q [5];
	logic [31:0] ck_q [4];
	logic [63:0] flg_q;
	logic [5:0]  fbt_q;
	logic [31:0] smp_tot_q;
	logic [31:0] sent_row_q;
	logic [31:0] cum_q;
	logic [OW-1:0] occ_ph_q;
	logic [KW-1:0] ck_ph_q;
	logic [FW-1:0] fl_ph_q;
	logic fire_occ_q, fire_ck_q, fire_fl_q;
	logic fire_occ, fire_ck, fire_fl;

	logic        hold_v_q;
	kind_t       hold_kind_q;
	logic [63:0] hold_word_q;
	logic        out_v_q, out_last_q;
	kind_t       out_kind_q;
	logic [63:0] out_word_q;

	logic        sampled;
	logic        has;
	kind_t       res_kind;
	logic [63:0] res_word;
	logic        adv, emit, out_free, out_load, fin_move;
	logic [5:0]  fbt_inc;
	logic [63:0] fl1_word, ins_v, ins_word;
	logic        crosses;

	assign dvs     = (sample_rate == '0) ? RATE_W'(1) : sample_rate;
	assign trial   = {rem_q, quo_q[31]};
	assign ge      = (trial >= {1'b0, dvs});
	assign sampled = (rem_q == '0);
	assign rc_n    = rc_q + 32'd1;

	assign fire_occ = (occ_ph_q == OW'(OCC_INTERVAL - 1)) || (rc_n == '0);
	assign fire_ck  = (ck_ph_q == KW'(CHECKPOINT_INTERVAL - 1)) || (rc_n == '0);
	assign fire_fl  = (fl_ph_q == FW'(FLAG_COUNTER_INTERVAL - 1)) || (rc_n == '0);

	assign out_free = !out_v_q || !out_stall;

	// flag bitmap helpers
	assign fbt_inc  = fbt_q + 6'd1;
	assign fl1_word = flg_q | (sampled ? (64'd1 << (~fbt_q)) : 64'd0);
	assign ins_v    = {smp_tot_q, 32'd0};
	assign ins_word = flg_q | (ins_v >> fbt_q);
	assign crosses  = fbt_q[5];

	always_comb begin
		has      = 1'b0;
		res_kind = KIND_BWT;
		res_word = bwt_q;
		unique case (slot_q)
			SL_BWT: begin
				has = (rc_q[4:0] == 5'd0);
			end
			SL_CK0: begin
				has = fire_ck_q; res_kind = KIND_CKPT; res_word = {32'd0, sc_q[1]};
			end
			SL_CK1: begin
				has = fire_ck_q; res_kind = KIND_CKPT; res_word = {32'd0, sc_q[2]};
			end
			SL_CK2: begin
				has = fire_ck_q; res_kind = KIND_CKPT; res_word = {32'd0, sc_q[3]};
			end
			SL_CK3: begin
				has = fire_ck_q; res_kind = KIND_CKPT; res_word = {32'd0, sc_q[4]};
			end
			SL_OCC: begin
				has      = fire_occ_q;
				res_kind = KIND_OCC;
				res_word = {16'(sc_q[1] - ck_q[0]), 16'(sc_q[2] - ck_q[1]),
					16'(sc_q[3] - ck_q[2]), 16'(sc_q[4] - ck_q[3])};
			end
			SL_FL1: begin
				has = (fbt_inc == 6'd0); res_kind = KIND_FLAG; res_word = fl1_word;
			end
			SL_FL2: begin
				has = fire_fl_q && crosses; res_kind = KIND_FLAG; res_word = ins_word;
			end
			SL_SMP: begin
				has      = sampled;
				res_kind = KIND_SAMP;
				res_word = {32'd0, {item_q.code, 30'd0} | quo_q};
			end
			SL_LBWT: begin
				has = item_q.last && (rc_q[4:0] != 5'd0);
			end
			SL_LFL: begin
				has = item_q.last && (fbt_q != 6'd0); res_kind = KIND_FLAG; res_word = flg_q;
			end
			SL_SENT: begin
				has = item_q.last; res_kind = KIND_SENT; res_word = {32'd0, sent_row_q};
			end
			SL_CUM0, SL_CUM1, SL_CUM2, SL_CUM3, SL_CUM4: begin
				has = item_q.last; res_kind = KIND_CUM; res_word = {32'd0, cum_q};
			end
			default: begin
				has = 1'b0;
			end
		endcase
	end

	// FSM: next state and control
	always_comb begin
		st_d     = st_q;
		slot_d   = slot_q;
		q_pop    = 1'b0;
		adv      = 1'b0;
		fin_move = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				q_pop = q_valid;
				if (q_valid) begin
					st_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == 5'd31) begin
					st_d = ST_UPD;
				end
			end
			ST_UPD: begin
				st_d   = ST_SLOT;
				slot_d = SL_BWT;
			end
			ST_SLOT: begin
				adv = !has || !hold_v_q || out_free;
				if (adv) begin
					if (slot_q == SL_CUM4) begin
						st_d = ST_FIN;
					end else begin
						slot_d = slot_t'(slot_q + 5'd1);
					end
				end
			end
			ST_FIN: begin
				if (!hold_v_q || out_free) begin
					fin_move = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	assign emit     = (st_q == ST_SLOT) && adv && has;
	assign out_load = (emit && hold_v_q) || (fin_move && hold_v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			slot_q <= SL_BWT;
		end else begin
			st_q   <= st_d;
			slot_q <= slot_d;
		end
	end

	// divider and item latch
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q    <= q_item;
			quo_q     <= q_item.pos;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (st_q == ST_DIV) begin
			rem_q     <= ge ? RATE_W'(trial - {1'b0, dvs}) : trial[RATE_W-1:0];
			quo_q     <= {quo_q[30:0], ge};
			div_cnt_q <= div_cnt_q + 5'd1;
		end
	end

	// layout state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q       <= '0;
			bwt_q      <= '0;
			flg_q      <= '0;
			fbt_q      <= 6'd32;
			smp_tot_q  <= '0;
			sent_row_q <= '0;
			cum_q      <= 32'd1;
			occ_ph_q   <= '0;
			ck_ph_q    <= '0;
			fl_ph_q    <= '0;
			fire_occ_q <= 1'b0;
			fire_ck_q  <= 1'b0;
			fire_fl_q  <= 1'b0;
			for (int i = 0; i < 5; i++) sc_q[i] <= '0;
			for (int i = 0; i < 4; i++) ck_q[i] <= '0;
		end else if (st_q == ST_UPD) begin
			bwt_q <= bwt_q | ({62'd0, item_q.code} << {~rc_q[4:0], 1'b0});
			sc_q[item_q.cidx] <= sc_q[item_q.cidx] + 32'd1;
			if (item_q.sent) begin
				sent_row_q <= rc_q;
			end
			rc_q       <= rc_n;
			fire_occ_q <= fire_occ;
			fire_ck_q  <= fire_ck;
			fire_fl_q  <= fire_fl;
			occ_ph_q   <= fire_occ ? '0 : occ_ph_q + OW'(1);
			ck_ph_q    <= fire_ck ? '0 : ck_ph_q + KW'(1);
			fl_ph_q    <= fire_fl ? '0 : fl_ph_q + FW'(1);
			if (sampled) begin
				smp_tot_q <= smp_tot_q + 32'd1;
			end
			cum_q <= 32'd1;
		end else if ((st_q == ST_SLOT) && adv) begin
			unique case (slot_q)
				SL_BWT:  if (has) bwt_q <= '0;
				SL_CK0:  if (has) ck_q[0] <= sc_q[1];
				SL_CK1:  if (has) ck_q[1] <= sc_q[2];
				SL_CK2:  if (has) ck_q[2] <= sc_q[3];
				SL_CK3:  if (has) ck_q[3] <= sc_q[4];
				SL_FL1: begin
					flg_q <= has ? 64'd0 : fl1_word;
					fbt_q <= fbt_inc;
				end
				SL_FL2: begin
					if (fire_fl_q) begin
						flg_q <= crosses ? (ins_v << (6'd0 - fbt_q)) : ins_word;
						fbt_q <= fbt_q + 6'd32;
					end
				end
				SL_CUM0: cum_q <= cum_q + sc_q[1];
				SL_CUM1: cum_q <= cum_q + sc_q[2];
				SL_CUM2: cum_q <= cum_q + sc_q[3];
				SL_CUM3: cum_q <= cum_q + sc_q[4];
				default: begin
				end
			endcase
		end else if (fin_move && item_q.last) begin
			// end of text: back to the reset state but for cum and the fire flags
			rc_q       <= '0;
			bwt_q      <= '0;
			flg_q      <= '0;
			fbt_q      <= 6'd32;
			smp_tot_q  <= '0;
			sent_row_q <= '0;
			occ_ph_q   <= '0;
			ck_ph_q    <= '0;
			fl_ph_q    <= '0;
			for (int i = 0; i < 5; i++) sc_q[i] <= '0;
			for (int i = 0; i < 4; i++) ck_q[i] <= '0;
		end
	end

	// one result held back so the final one can be marked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (emit) begin
				hold_v_q <= 1'b1;
			end else if (fin_move) begin
				hold_v_q <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			hold_kind_q <= res_kind;
			hold_word_q <= res_word;
		end
		if (out_load) begin
			out_kind_q <= hold_kind_q;
			out_word_q <= hold_word_q;
			out_last_q <= fin_move;
		end
	end

	assign out_valid   = out_v_q;
	assign stream_kind = out_kind_q;
	assign word        = out_word_q;
	assign last_of_run = out_last_q;

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) && (div_cnt_q != 5'd31) |=> (st_q == ST_DIV))
		else $error("divider left early");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !hold_v_q)
		else $error("held result left behind");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> (rem_q < dvs))
		else $error("remainder out of range");

endmodule

>>> hdl/fm_index_layout_builder.sv
// ----------------------------------------------------------------------------
// fm_index_layout_builder
// Builds the FM-index layout stream from suffix-array rows.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one suffix-array row per item, in
//    row order, with is_last on the final row of the text.
//  - Output channel (out_valid / out_stall): tagged layout words; last_of_run
//    marks the final word caused by a row. A row may cause no word.
//  - cfg_we / cfg_wdata write the sample rate; write only while idle.
// Flow: the back end runs a bit-serial restoring divider (pos / rate and
//  the remainder), an update step, then walks 17 result slots at one per
//  cycle, unless a held word waits on a stalled output, and a finishing
//  step. A two-entry queue lets rows be taken while the back end works,
//  and an output register plus one held-back word decouple the receiver.
// Reset: clears all layout state (flag bit position starts after the 32-bit
//  counter slot) and sets the sample rate to 8. After a last row the state
//  returns to them, but for cum and the fire flags; the sample rate is kept.
// Stall: an out_stall holds the output word; the back end waits once its
//  held word cannot move, and the queue then fills and raises in_stall.
// ----------------------------------------------------------------------------
module fm_index_layout_builder import fmib_pkg::*; #(
	parameter int unsigned OCC_INTERVAL          = OCC_INTERVAL_DEF,
	parameter int unsigned CHECKPOINT_INTERVAL   = CHECKPOINT_INTERVAL_DEF,
	parameter int unsigned FLAG_COUNTER_INTERVAL = FLAG_COUNTER_INTERVAL_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [RATE_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        prev_symbol,
	input  logic [POS_W-1:0]  suffix_pos,
	input  logic              is_last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        stream_kind,
	output logic [63:0]       word,
	output logic              last_of_run
);

	logic [RATE_W-1:0] sample_rate_q;
	logic              q_full, q_push, q_pop, q_valid;
	fmib_item_t        push_item, pop_item;

	// sample rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= RATE_RESET;
		end else if (cfg_we) begin
			sample_rate_q <= cfg_wdata;
		end
	end

	// front: take and classify rows
	fmib_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.prev_symbol (prev_symbol),
		.suffix_pos  (suffix_pos),
		.is_last     (is_last),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (push_item)
	);

	// queue between front and back
	fmib_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_item  (pop_item)
	);

	// back: divide, update, emit
	fmib_back #(
		.OCC_INTERVAL          (OCC_INTERVAL),
		.CHECKPOINT_INTERVAL   (CHECKPOINT_INTERVAL),
		.FLAG_COUNTER_INTERVAL (FLAG_COUNTER_INTERVAL)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_rate (sample_rate_q),
		.q_valid     (q_valid),
		.q_item      (pop_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.stream_kind (stream_kind),
		.word        (word),
		.last_of_run (last_of_run)
	);

endmodule
